[src/stt_pkg.sv]
package stt_pkg;

	// Buffer and position sizing
	localparam int MAX_TOK   = 32;
	localparam int POS_BITS  = 16;
	localparam int TOK_IDX_W = $clog2(MAX_TOK);
	localparam int TOK_LEN_W = $clog2(MAX_TOK + 1);

	// Descriptor queue sizing
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef logic [POS_BITS-1:0]  pos_t;
	typedef logic [TOK_LEN_W-1:0] tok_len_t;
	typedef logic [TOK_IDX_W-1:0] tok_idx_t;

	localparam pos_t POS_MAX = '1;

	// Character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;

	// Quote mode codes
	localparam logic [1:0] QM_NONE   = 2'd0;
	localparam logic [1:0] QM_DOUBLE = 2'd1;
	localparam logic [1:0] QM_SINGLE = 2'd2;

	typedef enum logic [3:0] {
		KIND_IDENT   = 4'd0,
		KIND_STRING  = 4'd1,
		KIND_OP      = 4'd2,
		KIND_EQUALS  = 4'd3,
		KIND_LCURLY  = 4'd4,
		KIND_RCURLY  = 4'd5,
		KIND_LPAREN  = 4'd6,
		KIND_RPAREN  = 4'd7,
		KIND_LSQUARE = 4'd8,
		KIND_RSQUARE = 4'd9,
		KIND_COLON   = 4'd10
	} kind_t;

	typedef struct packed {
		logic [7:0] in_char;
		logic       start_of_text;
	} stt_in_t;

	typedef struct packed {
		logic [7:0]  token_char;
		logic [3:0]  token_kind;
		logic [15:0] token_line;
		logic [15:0] token_column;
		logic [4:0]  char_position;
		logic        last_of_token;
		logic        truncated;
	} stt_out_t;

	// One queued job: optional replay of the buffered token, then an optional one-char token
	typedef struct packed {
		logic        send_buf;
		kind_t       kind_buf;
		logic [15:0] line;
		logic [15:0] col_buf;
		tok_len_t    len;
		logic        trunc;
		logic        send_ch;
		kind_t       kind_ch;
		logic [15:0] col_ch;
		logic [7:0]  ch;
	} stt_desc_t;

	typedef struct packed {
		logic     en;
		tok_idx_t addr;
		logic [7:0] data;
	} stt_buf_wr_t;

	typedef struct packed {
		logic buf_done;
	} stt_back_stat_t;

	function automatic logic [15:0] clamp16(pos_t v);
		logic [47:0] w;
		w = 48'(v);
		return (w > 48'hFFFF) ? 16'hFFFF : w[15:0];
	endfunction

	// Saturating column advance
	function automatic pos_t sat_add(pos_t a, logic [TOK_LEN_W:0] n);
		logic [POS_BITS:0] s;
		s = {1'b0, a} + (POS_BITS + 1)'(n);
		return (s >= {1'b0, POS_MAX}) ? POS_MAX : s[POS_BITS-1:0];
	endfunction

	// Flow characters: returns {hit, kind}
	function automatic logic [4:0] flow_kind(logic [7:0] c);
		logic [4:0] r;
		unique case (c)
			8'h3D:   r = {1'b1, KIND_EQUALS};
			8'h7B:   r = {1'b1, KIND_LCURLY};
			8'h7D:   r = {1'b1, KIND_RCURLY};
			8'h28:   r = {1'b1, KIND_LPAREN};
			8'h29:   r = {1'b1, KIND_RPAREN};
			8'h5B:   r = {1'b1, KIND_LSQUARE};
			8'h5D:   r = {1'b1, KIND_RSQUARE};
			8'h3A:   r = {1'b1, KIND_COLON};
			default: r = {1'b0, KIND_IDENT};
		endcase
		return r;
	endfunction

	function automatic logic is_op(logic [7:0] c);
		return (c == 8'h2B) || (c == 8'h21) || (c == 8'h7E) || (c == 8'h25) ||
			(c == 8'h2A) || (c == 8'h26) || (c == 8'h2F) || (c == 8'h2D) ||
			(c == 8'h7C) || (c == 8'h5E);
	endfunction

endpackage

[src/source_text_tokenizer_unit.sv]
// Channel  Handshake             Payload    Transaction
// in       in_valid / in_ready   in_data    one source byte (+ start_of_text)
// out      out_valid / out_ready out_data   one character of an emitted token
//
// The front takes one byte per cycle when not held; a byte that goes into the
// token buffer is held while the previous buffered token is still replaying.
// The back pops a job in ST_IDLE, then replays each buffered character through
// a buffer read (ST_RD) and then an output register load (ST_EMIT); a
// one-character flow or operator token adds a further load in ST_CHR.
// Reset clears line/column to one and all lexer modes; the buffer is not cleared.
// A full descriptor queue holds the front off; a stalled output register holds
// it off through the queue and through the buffer hold.
module source_text_tokenizer_unit import stt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  stt_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output stt_out_t out_data
);

	// Queue between classification and replay
	logic           q_full, q_push, q_pop, q_valid;
	stt_desc_t      q_wdesc, q_rdesc;
	stt_buf_wr_t    buf_wr;
	stt_back_stat_t back_stat;

	// Front: classify each byte, track line/column/modes, fill the buffer
	stt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_desc    (q_wdesc),
		.buf_wr    (buf_wr),
		.back_stat (back_stat)
	);

	// Short queue of token jobs; lets front and back stall on their own
	stt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdesc),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_rdesc)
	);

	// Back: replay token characters from the buffer into the output register
	stt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.buf_wr    (buf_wr),
		.q_valid   (q_valid),
		.q_desc    (q_rdesc),
		.q_pop     (q_pop),
		.back_stat (back_stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[src/stt_front.sv]
module stt_front import stt_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  stt_in_t        in_data,
	input  logic           q_full,
	output logic           q_push,
	output stt_desc_t      q_desc,
	output stt_buf_wr_t    buf_wr,
	input  stt_back_stat_t back_stat
);

	pos_t       line_q, col_q;
	tok_len_t   len_q;
	logic       ovf_q, comment_q, buf_pend_q;
	logic [1:0] quote_q;

	pos_t       b_line, b_col, n_line, n_col;
	tok_len_t   b_len, n_len;
	logic       b_ovf, n_ovf, b_comment, n_comment;
	logic [1:0] b_quote, n_quote;
	logic       need_push, accept;
	logic [7:0] c, qchar;
	logic [4:0] fk;
	stt_desc_t  d;

	assign c      = in_data.in_char;
	assign accept = in_valid && in_ready;
	assign fk     = flow_kind(c);

	always_comb begin
		// Reset values apply before this character when text starts over
		b_line    = in_data.start_of_text ? pos_t'(1) : line_q;
		b_col     = in_data.start_of_text ? pos_t'(1) : col_q;
		b_len     = in_data.start_of_text ? '0 : len_q;
		b_ovf     = in_data.start_of_text ? 1'b0 : ovf_q;
		b_comment = in_data.start_of_text ? 1'b0 : comment_q;
		b_quote   = in_data.start_of_text ? QM_NONE : quote_q;
		qchar     = (b_quote == QM_DOUBLE) ? CH_DQUOTE : CH_SQUOTE;

		n_line    = b_line;
		n_col     = b_col;
		n_len     = b_len;
		n_ovf     = b_ovf;
		n_comment = b_comment;
		n_quote   = b_quote;
		need_push = 1'b0;

		d          = '0;
		d.line     = clamp16(b_line);
		d.kind_buf = KIND_IDENT;
		d.kind_ch  = KIND_IDENT;
		d.col_buf  = clamp16(b_col);
		d.len      = b_len;
		d.trunc    = b_ovf;
		d.ch       = c;

		priority if (c == CH_NUL) begin
			// ignored character
		end else if (b_comment) begin
			if (c == CH_NL) begin
				n_line    = (b_line < POS_MAX) ? b_line + pos_t'(1) : b_line;
				n_col     = pos_t'(1);
				n_len     = '0;
				n_ovf     = 1'b0;
				n_comment = 1'b0;
			end else if (c == CH_HASH) begin
				n_comment = 1'b0;
			end
		end else if (b_quote != QM_NONE) begin
			if (c == qchar) begin
				n_quote    = QM_NONE;
				d.send_buf = (b_len != '0);
				d.kind_buf = KIND_STRING;
				n_col      = sat_add(b_col, {1'b0, b_len} + 1'b1);
				n_len      = '0;
				n_ovf      = 1'b0;
			end else begin
				need_push = 1'b1;
			end
		end else if (c == CH_SPACE) begin
			d.send_buf = (b_len != '0);
			n_col      = sat_add(b_col, {1'b0, b_len} + 1'b1);
			n_len      = '0;
			n_ovf      = 1'b0;
		end else if (c == CH_HASH) begin
			d.send_buf = (b_len != '0);
			n_col      = sat_add(b_col, {1'b0, b_len});
			n_len      = '0;
			n_ovf      = 1'b0;
			n_comment  = 1'b1;
		end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
			d.send_buf = (b_len != '0);
			n_quote    = (c == CH_DQUOTE) ? QM_DOUBLE : QM_SINGLE;
			n_col      = sat_add(b_col, {1'b0, b_len} + 1'b1);
			n_len      = '0;
			n_ovf      = 1'b0;
		end else if (c == CH_NL) begin
			d.send_buf = (b_len != '0);
			n_line     = (b_line < POS_MAX) ? b_line + pos_t'(1) : b_line;
			n_col      = pos_t'(1);
			n_len      = '0;
			n_ovf      = 1'b0;
		end else if (fk[4] || is_op(c)) begin
			// Flush the pending identifier, then the one-character token
			d.send_buf = (b_len != '0);
			d.send_ch  = 1'b1;
			d.kind_ch  = fk[4] ? kind_t'(fk[3:0]) : KIND_OP;
			d.col_ch   = clamp16(sat_add(b_col, {1'b0, b_len}));
			n_col      = sat_add(b_col, {1'b0, b_len} + 1'b1);
			n_len      = '0;
			n_ovf      = 1'b0;
		end else begin
			need_push = 1'b1;
		end

		buf_wr      = '0;
		buf_wr.addr = b_len[TOK_IDX_W-1:0];
		buf_wr.data = c;
		if (need_push) begin
			if (b_len < tok_len_t'(MAX_TOK)) begin
				buf_wr.en = accept;
				n_len     = b_len + 1'b1;
			end else begin
				n_ovf = 1'b1;
			end
		end
	end

	// Hold a buffer write back while the previous token is still being replayed
	assign in_ready = !q_full && !(need_push && buf_pend_q);
	assign q_push   = accept && (d.send_buf || d.send_ch);
	assign q_desc   = d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q     <= pos_t'(1);
			col_q      <= pos_t'(1);
			len_q      <= '0;
			ovf_q      <= 1'b0;
			comment_q  <= 1'b0;
			quote_q    <= QM_NONE;
			buf_pend_q <= 1'b0;
		end else begin
			if (accept) begin
				line_q    <= n_line;
				col_q     <= n_col;
				len_q     <= n_len;
				ovf_q     <= n_ovf;
				comment_q <= n_comment;
				quote_q   <= n_quote;
			end
			if (q_push && d.send_buf) begin
				buf_pend_q <= 1'b1;
			end else if (back_stat.buf_done) begin
				buf_pend_q <= 1'b0;
			end
		end
	end

endmodule

[src/stt_fifo.sv]
module stt_fifo import stt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  stt_desc_t push_data,
	output logic      full,
	input  logic      pop,
	output logic      not_empty,
	output stt_desc_t pop_data
);

	stt_desc_t          ent_q [QDEPTH];
	logic [QPTR_W-1:0]  wp_q, rp_q;
	logic [QCNT_W-1:0]  cnt_q;

	assign full      = (cnt_q == QCNT_W'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[src/stt_back.sv]
module stt_back import stt_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  stt_buf_wr_t    buf_wr,
	input  logic           q_valid,
	input  stt_desc_t      q_desc,
	output logic           q_pop,
	output stt_back_stat_t back_stat,
	output logic           out_valid,
	input  logic           out_ready,
	output stt_out_t       out_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_EMIT,
		ST_CHR
	} state_t;

	state_t     state_q;
	stt_desc_t  desc_q;
	tok_idx_t   idx_q;
	logic [7:0] rdata_q;
	logic [7:0] buf_mem [MAX_TOK];
	logic       out_valid_q;
	stt_out_t   out_data_q;
	logic       out_free, last, load_out;

	assign out_free  = !out_valid_q || out_ready;
	assign last      = (tok_len_t'(idx_q) + 1'b1 == desc_q.len);
	assign load_out  = ((state_q == ST_EMIT) || (state_q == ST_CHR)) && out_free;
	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign back_stat.buf_done = (state_q == ST_EMIT) && out_free && last;

	always_ff @(posedge clk) begin
		if (buf_wr.en) begin
			buf_mem[buf_wr.addr] <= buf_wr.data;
		end
		if (state_q == ST_RD) begin
			rdata_q <= buf_mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			desc_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// Load a new transaction, or drop valid once the current one is taken
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						desc_q <= q_desc;
						idx_q  <= '0;
						state_q <= q_desc.send_buf ? ST_RD : ST_CHR;
					end
				end
				ST_RD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_data_q  <= '{
							token_char:    rdata_q,
							token_kind:    desc_q.kind_buf,
							token_line:    desc_q.line,
							token_column:  desc_q.col_buf,
							char_position: 5'(idx_q),
							last_of_token: last,
							truncated:     desc_q.trunc
						};
						if (last) begin
							state_q <= desc_q.send_ch ? ST_CHR : ST_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				ST_CHR: begin
					if (out_free) begin
						out_data_q  <= '{
							token_char:    desc_q.ch,
							token_kind:    desc_q.kind_ch,
							token_line:    desc_q.line,
							token_column:  desc_q.col_ch,
							char_position: 5'd0,
							last_of_token: 1'b1,
							truncated:     1'b0
						};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
